// ===== design/spq_pkg.sv =====
package spq_pkg;

    localparam int FIELD_W  = 16;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_POP     = 2'd1,
        OP_DEL_KEY = 2'd2,
        OP_DEL_PAY = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // flags rippled from a cell to its right-hand neighbor
    typedef struct packed {
        logic ins;      // new entry belongs at or before this cell
        logic found;    // a removal hit lies at or before this cell
    } link_t;

endpackage

// ===== design/sorted_priority_queue.sv =====
// Sorted priority queue built as a row of CAPACITY cells, smallest key at the head.
// A request is taken when start is high and busy is low; busy then stays high for one
// cycle while every cell compares against the request and shifts in the same edge,
// after the request has been held in the registered request stage ahead of the cell row.
// done pulses for exactly one cycle with the result, both registered from the busy cycle;
// the receiver cannot stall it, so results must be captured on that cycle.
// Equal keys leave in arrival order. out_key and out_payload show the removed entry,
// otherwise the head after the request, or zero when the queue is empty.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY      = 16,
    parameter int KEY_WIDTH     = 16,
    parameter int PAYLOAD_WIDTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          func,
    input  logic [FIELD_W-1:0]  key,
    input  logic [FIELD_W-1:0]  payload,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [FIELD_W-1:0]  out_key,
    output logic [FIELD_W-1:0]  out_payload,
    output logic [COUNT_W-1:0]  count,
    output logic                is_empty
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                     exec_reg;
    op_t                      op_reg;
    logic [KEY_WIDTH-1:0]     req_key_reg;
    logic [PAYLOAD_WIDTH-1:0] req_pay_reg;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    logic                     done_reg;
    status_t                  status_reg, status_next;
    logic [FIELD_W-1:0]       out_key_reg, out_key_next;
    logic [FIELD_W-1:0]       out_pay_reg, out_pay_next;
    logic [COUNT_W-1:0]       count_reg;
    logic                     empty_reg;

    link_t                    link [CAPACITY+1];
    logic                     hit        [CAPACITY];
    logic                     cvalid     [CAPACITY];
    logic [KEY_WIDTH-1:0]     ckey       [CAPACITY];
    logic [PAYLOAD_WIDTH-1:0] cpay       [CAPACITY];
    logic                     cvalid_nxt [CAPACITY];
    logic [KEY_WIDTH-1:0]     ckey_nxt   [CAPACITY];
    logic [PAYLOAD_WIDTH-1:0] cpay_nxt   [CAPACITY];

    logic                     full;
    logic                     found;
    logic [KEY_WIDTH-1:0]     rem_key;
    logic [PAYLOAD_WIDTH-1:0] rem_pay;

    assign busy    = exec_reg;
    assign link[0] = '0;
    assign full    = cvalid[CAPACITY-1];
    assign found   = link[CAPACITY].found;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic                     lv, rv;
            logic [KEY_WIDTH-1:0]     lk, rk;
            logic [PAYLOAD_WIDTH-1:0] lp, rp;

            if (g == 0)
            begin : g_head
                assign lv = 1'b0;
                assign lk = '0;
                assign lp = '0;
            end
            else
            begin : g_mid
                assign lv = cvalid[g-1];
                assign lk = ckey[g-1];
                assign lp = cpay[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_tail
                assign rv = 1'b0;
                assign rk = '0;
                assign rp = '0;
            end
            else
            begin : g_body
                assign rv = cvalid[g+1];
                assign rk = ckey[g+1];
                assign rp = cpay[g+1];
            end

            spq_cell #(
                .KEY_WIDTH     (KEY_WIDTH),
                .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .exec        (exec_reg),
                .op          (op_reg),
                .req_key     (req_key_reg),
                .req_pay     (req_pay_reg),
                .full        (full),
                .link_in     (link[g]),
                .left_valid  (lv),
                .left_key    (lk),
                .left_pay    (lp),
                .right_valid (rv),
                .right_key   (rk),
                .right_pay   (rp),
                .link_out    (link[g+1]),
                .hit         (hit[g]),
                .valid       (cvalid[g]),
                .key         (ckey[g]),
                .pay         (cpay[g]),
                .valid_next  (cvalid_nxt[g]),
                .key_next    (ckey_nxt[g]),
                .pay_next    (cpay_nxt[g])
            );
        end
    endgenerate

    // one-hot select of the removed entry
    always_comb
    begin
        rem_key = '0;
        rem_pay = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rem_key = rem_key | (ckey[i] & {KEY_WIDTH{hit[i]}});
            rem_pay = rem_pay | (cpay[i] & {PAYLOAD_WIDTH{hit[i]}});
        end
    end

    always_comb
    begin
        cnt_next     = cnt_reg;
        status_next  = ST_DONE;
        out_key_next = '0;
        out_pay_next = '0;
        if (cvalid_nxt[0])
        begin
            out_key_next = FIELD_W'(ckey_nxt[0]);
            out_pay_next = FIELD_W'(cpay_nxt[0]);
        end
        case (op_reg)
            OP_PUSH:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                if (found)
                begin
                    cnt_next     = cnt_reg - CNT_W'(1);
                    out_key_next = FIELD_W'(rem_key);
                    out_pay_next = FIELD_W'(rem_pay);
                end
                else
                begin
                    status_next = ST_MISS;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            exec_reg <= start && !exec_reg;
            done_reg <= exec_reg;
            if (exec_reg)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !exec_reg)
        begin
            op_reg      <= op_t'(func);
            req_key_reg <= KEY_WIDTH'(key);
            req_pay_reg <= PAYLOAD_WIDTH'(payload);
        end
        if (exec_reg)
        begin
            status_reg  <= status_next;
            out_key_reg <= out_key_next;
            out_pay_reg <= out_pay_next;
            count_reg   <= COUNT_W'(cnt_next);
            empty_reg   <= (cnt_next == '0);
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign out_key     = out_key_reg;
    assign out_payload = out_pay_reg;
    assign count       = count_reg;
    assign is_empty    = empty_reg;

endmodule

// ===== design/spq_cell.sv =====
module spq_cell
    import spq_pkg::*;
#(
    parameter int KEY_WIDTH     = 16,
    parameter int PAYLOAD_WIDTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     exec,
    input  op_t                      op,
    input  logic [KEY_WIDTH-1:0]     req_key,
    input  logic [PAYLOAD_WIDTH-1:0] req_pay,
    input  logic                     full,
    input  link_t                    link_in,
    input  logic                     left_valid,
    input  logic [KEY_WIDTH-1:0]     left_key,
    input  logic [PAYLOAD_WIDTH-1:0] left_pay,
    input  logic                     right_valid,
    input  logic [KEY_WIDTH-1:0]     right_key,
    input  logic [PAYLOAD_WIDTH-1:0] right_pay,
    output link_t                    link_out,
    output logic                     hit,
    output logic                     valid,
    output logic [KEY_WIDTH-1:0]     key,
    output logic [PAYLOAD_WIDTH-1:0] pay,
    output logic                     valid_next,
    output logic [KEY_WIDTH-1:0]     key_next,
    output logic [PAYLOAD_WIDTH-1:0] pay_next
);

    logic                     valid_reg;
    logic [KEY_WIDTH-1:0]     key_reg;
    logic [PAYLOAD_WIDTH-1:0] pay_reg;
    logic                     match;
    logic                     ins;

    always_comb
    begin
        case (op)
            OP_POP:     match = valid_reg;
            OP_DEL_KEY: match = valid_reg && (key_reg == req_key);
            OP_DEL_PAY: match = valid_reg && (pay_reg == req_pay);
            default:    match = 1'b0;
        endcase
        // strictly greater keeps equal keys in arrival order
        ins            = !valid_reg || (key_reg > req_key);
        link_out.ins   = ins;
        link_out.found = link_in.found | match;
        hit            = match & ~link_in.found;
    end

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        pay_next   = pay_reg;
        if (exec)
        begin
            case (op)
                OP_PUSH:
                begin
                    if (!full)
                    begin
                        if (link_in.ins)
                        begin
                            valid_next = left_valid;
                            key_next   = left_key;
                            pay_next   = left_pay;
                        end
                        else if (ins)
                        begin
                            valid_next = 1'b1;
                            key_next   = req_key;
                            pay_next   = req_pay;
                        end
                    end
                end
                default:
                begin
                    // close the gap by shifting every entry from the first hit on toward the head
                    if (link_out.found)
                    begin
                        valid_next = right_valid;
                        key_next   = right_key;
                        pay_next   = right_pay;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign pay   = pay_reg;

endmodule

// ===== tb/tb_sorted_priority_queue.sv =====
module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int CAP        = 16;
    localparam int STALL_MAX  = 2000;
    localparam int RAND_ITEMS = 900;

    typedef struct packed {
        status_t              st;
        logic [FIELD_W-1:0]   k;
        logic [FIELD_W-1:0]   p;
        logic [COUNT_W-1:0]   cnt;
        logic                 emp;
    } qresult_t;

    typedef struct packed {
        op_t                  f;
        logic [FIELD_W-1:0]   k;
        logic [FIELD_W-1:0]   p;
        int                   reps;
        bit                   typed;
        qresult_t             want;
    } drow_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          func;
    logic [FIELD_W-1:0]  key;
    logic [FIELD_W-1:0]  payload;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  out_key;
    logic [FIELD_W-1:0]  out_payload;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;

    // shadow copy of the sorted entries
    logic [FIELD_W-1:0] q_key [0:CAP-1];
    logic [FIELD_W-1:0] q_pay [0:CAP-1];
    int                 depth;

    qresult_t pending [$];
    drow_t    plan [$];

    bit       forced_valid;
    qresult_t forced_want;
    bit       gaps_on;

    int errors;
    int n_requests;
    int n_results;
    int n_full;
    int n_miss;
    int peak_depth;
    int stall;

    sorted_priority_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .key         (key),
        .payload     (payload),
        .done        (done),
        .status      (status),
        .out_key     (out_key),
        .out_payload (out_payload),
        .count       (count),
        .is_empty    (is_empty)
    );

    always #5 clk = ~clk;

    function automatic qresult_t apply_request(op_t f, logic [FIELD_W-1:0] k,
                                               logic [FIELD_W-1:0] p);
        qresult_t r;
        int       pos;
        int       hit;
        int       i;
        bit       removed;
        bit       found;
        r.st = ST_DONE;
        r.k = '0;
        r.p = '0;
        removed = 1'b0;
        if (f == OP_PUSH)
        begin
            if (depth >= CAP)
            begin
                r.st = ST_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < depth && q_key[pos] <= k)
                    pos++;
                for (i = depth; i > pos; i--)
                begin
                    q_key[i] = q_key[i-1];
                    q_pay[i] = q_pay[i-1];
                end
                q_key[pos] = k;
                q_pay[pos] = p;
                depth++;
            end
        end
        else
        begin
            hit = depth;
            found = 1'b0;
            if (f == OP_POP)
            begin
                hit = 0;
            end
            else
            begin
                for (i = 0; i < depth; i++)
                begin
                    if (!found && ((f == OP_DEL_KEY) ? (q_key[i] == k) : (q_pay[i] == p)))
                    begin
                        hit = i;
                        found = 1'b1;
                    end
                end
            end
            if (hit < depth)
            begin
                r.k = q_key[hit];
                r.p = q_pay[hit];
                for (i = hit; i + 1 < depth; i++)
                begin
                    q_key[i] = q_key[i+1];
                    q_pay[i] = q_pay[i+1];
                end
                depth--;
                removed = 1'b1;
            end
            else
            begin
                r.st = ST_MISS;
            end
        end
        if (!removed && depth > 0)
        begin
            r.k = q_key[0];
            r.p = q_pay[0];
        end
        r.cnt = depth[COUNT_W-1:0];
        r.emp = (depth == 0);
        return r;
    endfunction

    // request and result bookkeeping, sampled at the rising edge
    always @(posedge clk)
    begin
        qresult_t w;
        if (rst_n)
        begin
            if (done)
            begin
                n_results++;
                if (pending.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: status=%0d key=%h payload=%h count=%0d",
                                 status, out_key, out_payload, count);
                end
                else
                begin
                    w = pending.pop_front();
                    if (status !== w.st || out_key !== w.k || out_payload !== w.p ||
                        count !== w.cnt || is_empty !== w.emp)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: expected st=%0d key=%h pay=%h cnt=%0d emp=%0b",
                                      " got st=%0d key=%h pay=%h cnt=%0d emp=%0b"},
                                     w.st, w.k, w.p, w.cnt, w.emp,
                                     status, out_key, out_payload, count, is_empty);
                    end
                end
            end
            if (start && !busy)
            begin
                n_requests++;
                w = apply_request(op_t'(func), key, payload);
                if (w.st == ST_FULL)
                    n_full++;
                if (w.st == ST_MISS)
                    n_miss++;
                if (depth > peak_depth)
                    peak_depth = depth;
                if (forced_valid)
                    w = forced_want;
                pending.push_back(w);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall = 0;
            else
                stall++;
            if (stall >= STALL_MAX)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic issue(op_t f, logic [FIELD_W-1:0] k, logic [FIELD_W-1:0] p,
                         bit typed, qresult_t want);
        if (gaps_on)
        begin
            while ($urandom_range(99) < 25)
            begin
                @(negedge clk);
                start = 1'b0;
            end
        end
        @(negedge clk);
        start = 1'b1;
        func = f;
        key = k;
        payload = p;
        forced_valid = typed;
        forced_want = want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(op_t f, logic [FIELD_W-1:0] k, logic [FIELD_W-1:0] p, int reps,
                           bit typed, status_t st, logic [FIELD_W-1:0] wk,
                           logic [FIELD_W-1:0] wp, logic [COUNT_W-1:0] wc, logic we);
        drow_t row;
        row.f = f;
        row.k = k;
        row.p = p;
        row.reps = reps;
        row.typed = typed;
        row.want.st = st;
        row.want.k = wk;
        row.want.p = wp;
        row.want.cnt = wc;
        row.want.emp = we;
        plan.push_back(row);
    endtask

    // mix of small values, extremes, stored values and full-range values
    function automatic logic [FIELD_W-1:0] pick_value(bit from_keys);
        logic [FIELD_W-1:0] v;
        case ($urandom_range(3))
            0: v = FIELD_W'($urandom_range(16'hffff));
            1: v = FIELD_W'($urandom_range(3));
            2: v = $urandom_range(1) ? 16'hffff : 16'h0000;
            default:
            begin
                if (depth > 0)
                    v = from_keys ? q_key[$urandom_range(depth-1)]
                                  : q_pay[$urandom_range(depth-1)];
                else
                    v = FIELD_W'($urandom_range(16'hffff));
            end
        endcase
        return v;
    endfunction

    initial
    begin
        drow_t              row;
        op_t                f;
        logic [FIELD_W-1:0] k;
        logic [FIELD_W-1:0] p;
        int                 n;
        int                 i;
        int                 push_bias;

        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        func = OP_PUSH;
        key = '0;
        payload = '0;
        forced_valid = 1'b0;
        forced_want = '0;
        gaps_on = 1'b1;
        errors = 0;
        n_requests = 0;
        n_results = 0;
        n_full = 0;
        n_miss = 0;
        peak_depth = 0;
        stall = 0;
        depth = 0;
        push_bias = 50;

        // empty queue, extremes, equal keys, misses, then fill past capacity and drain
        add_row(OP_POP,     16'h0000, 16'h0000, 1,  1, ST_MISS, 16'h0000, 16'h0000, 0, 1);
        add_row(OP_DEL_KEY, 16'h0000, 16'h0000, 1,  1, ST_MISS, 16'h0000, 16'h0000, 0, 1);
        add_row(OP_DEL_PAY, 16'hffff, 16'hffff, 1,  1, ST_MISS, 16'h0000, 16'h0000, 0, 1);
        add_row(OP_PUSH,    16'hffff, 16'hffff, 1,  1, ST_DONE, 16'hffff, 16'hffff, 1, 0);
        add_row(OP_PUSH,    16'h0000, 16'h0000, 1,  1, ST_DONE, 16'h0000, 16'h0000, 2, 0);
        add_row(OP_PUSH,    16'h8000, 16'h1234, 1,  0, ST_DONE, '0, '0, '0, 1'b0);
        add_row(OP_PUSH,    16'h8000, 16'h5678, 1,  0, ST_DONE, '0, '0, '0, 1'b0);
        add_row(OP_PUSH,    16'h8000, 16'h0000, 1,  0, ST_DONE, '0, '0, '0, 1'b0);
        add_row(OP_DEL_KEY, 16'h8000, 16'h0000, 1,  0, ST_DONE, '0, '0, '0, 1'b0);
        add_row(OP_DEL_PAY, 16'h0000, 16'h0000, 1,  0, ST_DONE, '0, '0, '0, 1'b0);
        add_row(OP_DEL_KEY, 16'h4321, 16'h0000, 1,  0, ST_DONE, '0, '0, '0, 1'b0);
        add_row(OP_DEL_PAY, 16'h0000, 16'habcd, 1,  0, ST_DONE, '0, '0, '0, 1'b0);
        add_row(OP_POP,     16'h0000, 16'h0000, 3,  0, ST_DONE, '0, '0, '0, 1'b0);
        add_row(OP_POP,     16'h0000, 16'h0000, 1,  1, ST_MISS, 16'h0000, 16'h0000, 0, 1);
        add_row(OP_PUSH,    16'h0010, 16'h0100, 16, 0, ST_DONE, '0, '0, '0, 1'b0);
        add_row(OP_PUSH,    16'h0000, 16'hffff, 1,  0, ST_DONE, '0, '0, '0, 1'b0);
        add_row(OP_PUSH,    16'hffff, 16'h0000, 1,  0, ST_DONE, '0, '0, '0, 1'b0);
        add_row(OP_DEL_KEY, 16'h001f, 16'h0000, 1,  0, ST_DONE, '0, '0, '0, 1'b0);
        add_row(OP_PUSH,    16'h0018, 16'hbeef, 1,  0, ST_DONE, '0, '0, '0, 1'b0);
        add_row(OP_DEL_PAY, 16'h0000, 16'h0100, 1,  0, ST_DONE, '0, '0, '0, 1'b0);
        add_row(OP_POP,     16'h0000, 16'h0000, 16, 0, ST_DONE, '0, '0, '0, 1'b0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (n = 0; n < plan.size(); n++)
        begin
            row = plan[n];
            for (i = 0; i < row.reps; i++)
                issue(row.f, row.k + i[FIELD_W-1:0], row.p + i[FIELD_W-1:0],
                      row.typed, row.want);
        end
        drain();

        gaps_on = 1'b0;
        for (n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == 200)
                gaps_on = 1'b1;
            // vary at random between fill-heavy and drain-heavy stretches
            if (n % 100 == 0)
                push_bias = $urandom_range(20, 80);
            if (n % 150 == 149)
                drain();
            if ($urandom_range(99) < push_bias)
                f = OP_PUSH;
            else
                f = op_t'($urandom_range(OP_POP, OP_DEL_PAY));
            k = pick_value(1'b1);
            p = pick_value(1'b0);
            issue(f, k, p, 1'b0, '0);
        end

        drain();
        repeat (4) @(posedge clk);
        if (pending.size() != 0)
        begin
            errors++;
            $display("%0d expected results never arrived", pending.size());
        end
        $display("covered %0d requests, %0d results: %0d refused when full, %0d misses",
                 n_requests, n_results, n_full, n_miss);
        $display("peak occupancy %0d of %0d entries, %0d errors", peak_depth, CAP, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
tb/tb_sorted_priority_queue.sv
